[hdl/asw_pkg.sv]
// Package for the alphabet shift decoder with word reversal.
// Holds the sizes, register indexes and character constants shared by the top level and the testbench.
// No dependencies.
package asw_pkg;

  localparam int AlphabetMax = 16;
  localparam int WordMax = 63;
  localparam int WordAw = 6;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIndexW-1:0] RegAlphabetLow = 3'd0;
  localparam logic [CfgIndexW-1:0] RegAlphabetHigh = 3'd1;
  localparam logic [CfgIndexW-1:0] RegAlphabetLength = 3'd2;
  localparam logic [CfgIndexW-1:0] RegShift = 3'd3;
  localparam logic [CfgIndexW-1:0] RegChunkLength = 3'd4;

  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharNewline = 8'h0a;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CharLowerA) && (c <= CharLowerZ)) ||
           ((c >= CharUpperA) && (c <= CharUpperZ));
  endfunction

endpackage

[hdl/asw_in_if.sv]
// Input channel of the decoder: one ciphertext byte per transfer.
// Depends on nothing.
interface asw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output in_char, output end_of_text, input ready);
  modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

[hdl/asw_out_if.sv]
// Output channel of the decoder: one decoded byte per transfer.
// Depends on nothing.
interface asw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

[hdl/asw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module asw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/asw_mod.sv]
// Iterative remainder unit: signed shift modulo alphabet length, non-negative.
// One quotient bit per cycle. Depends on nothing.
module asw_mod (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [8:0] shift,
  input  logic [4:0] n,
  output logic       done,
  output logic [3:0] r
);

  logic       busy;
  logic [3:0] cnt;
  logic [8:0] mag;
  logic       neg;
  logic [4:0] rem;
  logic [5:0] trial;
  logic [4:0] rem_next;
  logic [4:0] r_wide;

  assign trial = {rem, mag[8]};
  assign rem_next = (trial >= {1'b0, n}) ? 5'(trial - {1'b0, n}) : trial[4:0];
  assign r_wide = (neg && (rem != 5'd0)) ? 5'(n - rem) : rem;
  assign r = r_wide[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 4'd9;
      end else if (busy) begin
        cnt <= 4'(cnt - 4'd1);
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= shift[8];
      mag <= shift[8] ? 9'(-shift) : shift;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next;
      mag <= {mag[7:0], 1'b0};
    end
  end

endmodule

[hdl/alphabet_shift_word_reverse_decoder_top.sv]
// Top level of the alphabet shift decoder with word reversal.
// Depends on asw_pkg, asw_in_if, asw_out_if, asw_mod and asw_ram.
//
// Each byte is substituted, then letters are held in a word RAM and sent out
// reversed when a non-letter, a chunk end or the end of text arrives. One
// byte at a time is in work: the transfer is taken, the remainder unit runs
// nine shift-and-subtract steps and gives its done flag, the alphabet entries
// are compared in turn up to the first match (up to sixteen) and a decision
// step follows. A flush then reads each held letter from the RAM and loads it
// into the output, closes and, after a non-letter, sends that byte last, with
// any stall from the output side. The word RAM needs no clearing pass after reset.
module alphabet_shift_word_reverse_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [asw_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [asw_pkg::CfgDataW-1:0]       cfg_wdata,
  asw_in_if.sink                             text,
  asw_out_if.source                          decoded
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_TAIL   = 3'd6;

  logic [2:0]   state;
  logic [63:0]  alphabet_low;
  logic [63:0]  alphabet_high;
  logic [4:0]   alphabet_length;
  logic [8:0]   shift;
  logic [6:0]   chunk_length;

  logic [7:0]   ch;
  logic         eot;
  logic [7:0]   sub_ch;
  logic [3:0]   idx;
  logic [asw_pkg::WordAw-1:0] wc;
  logic [asw_pkg::WordAw-1:0] pos;
  logic         tail;
  logic         out_valid;
  logic [7:0]   out_char;
  logic         out_last;

  logic [127:0] alpha_all;
  logic [4:0]   n;
  logic [6:0]   cl;
  logic [6:0]   lim;
  logic [6:0]   pos_inc;
  logic         end_chunk;
  logic         letter;
  logic         out_free;
  logic         out_load;
  logic         mod_start;
  logic         mod_done;
  logic [3:0]   r;
  logic [4:0]   sum;
  logic [4:0]   jw;
  logic [7:0]   entry_idx;
  logic [7:0]   entry_rot;
  logic         ram_we;
  logic         ram_re;
  logic [7:0]   ram_rdata;

  assign alpha_all = {alphabet_high, alphabet_low};
  assign n = (alphabet_length == 5'd0) ? 5'd1 :
             (alphabet_length > 5'(asw_pkg::AlphabetMax)) ? 5'(asw_pkg::AlphabetMax) :
             alphabet_length;
  assign cl = (chunk_length < 7'd2) ? 7'd2 : (chunk_length > 7'd64) ? 7'd64 : chunk_length;
  assign lim = (7'(cl - 7'd1) > 7'(asw_pkg::WordMax)) ? 7'(asw_pkg::WordMax) :
               7'(cl - 7'd1);
  assign pos_inc = 7'({1'b0, pos} + 7'd1);
  assign end_chunk = (sub_ch == asw_pkg::CharNewline) || (pos_inc >= lim) || eot;
  assign letter = asw_pkg::is_letter(sub_ch);
  assign out_free = !out_valid || decoded.ready;
  assign out_load = ((state == S_WAIT) || (state == S_TAIL)) && out_free;

  assign entry_idx = alpha_all[{idx, 3'b000} +: 8];
  assign sum = 5'({1'b0, idx} + {1'b0, r});
  assign jw = (sum >= n) ? 5'(sum - n) : sum;
  assign entry_rot = alpha_all[{jw[3:0], 3'b000} +: 8];

  assign mod_start = (state == S_IDLE) && text.valid;
  assign ram_we = (state == S_DECIDE) && letter;
  assign ram_re = (state == S_FLUSH) && (wc != '0);

  assign text.ready = (state == S_IDLE);
  assign decoded.valid = out_valid;
  assign decoded.out_char = out_char;
  assign decoded.last_of_run = out_last;

  asw_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .shift (shift),
    .n     (n),
    .done  (mod_done),
    .r     (r)
  );

  asw_ram #(
    .WIDTH (8),
    .DEPTH (asw_pkg::WordMax)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wc),
    .wdata (sub_ch),
    .re    (ram_re),
    .raddr (6'(wc - 6'd1)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low <= '0;
      alphabet_high <= '0;
      alphabet_length <= 5'd1;
      shift <= '0;
      chunk_length <= 7'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        asw_pkg::RegAlphabetLow: alphabet_low <= cfg_wdata;
        asw_pkg::RegAlphabetHigh: alphabet_high <= cfg_wdata;
        asw_pkg::RegAlphabetLength: alphabet_length <= cfg_wdata[4:0];
        asw_pkg::RegShift: shift <= cfg_wdata[8:0];
        asw_pkg::RegChunkLength: chunk_length <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wc <= '0;
      pos <= '0;
      tail <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (decoded.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (text.valid) begin
            ch <= text.in_char;
            eot <= text.end_of_text;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (entry_idx == ch) begin
            sub_ch <= entry_rot;
            state <= S_DECIDE;
          end else if (5'({1'b0, idx} + 5'd1) >= n) begin
            sub_ch <= ch;
            state <= S_DECIDE;
          end else begin
            idx <= 4'(idx + 4'd1);
          end
        end
        S_DECIDE: begin
          if (letter) begin
            wc <= 6'(wc + 6'd1);
          end
          tail <= !letter;
          pos <= end_chunk ? '0 : pos_inc[5:0];
          state <= (!letter || end_chunk) ? S_FLUSH : S_IDLE;
        end
        S_FLUSH: begin
          if (wc != '0) begin
            wc <= 6'(wc - 6'd1);
            state <= S_WAIT;
          end else begin
            state <= tail ? S_TAIL : S_IDLE;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_char <= ram_rdata;
            out_last <= (wc == '0) && !tail;
            state <= S_FLUSH;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_char <= sub_ch;
            out_last <= 1'b1;
            tail <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_word_within_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (wc <= pos))
    else $error("held word is longer than the current chunk");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready) |=> !text.ready)
    else $error("input accepted while an item is in work");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder unit finished outside its phase");

  a_output_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !decoded.ready) |=>
      (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("decoded byte changed while waiting for its transfer");
`endif

endmodule

[tb/alphabet_shift_word_reverse_decoder_top_tb.sv]
// Testbench for alphabet_shift_word_reverse_decoder_top: directed table, random text, then a long word.
// Every decoded byte is checked against a predictor kept inside this module.
// Depends on asw_pkg, asw_in_if, asw_out_if and the decoder RTL.
module alphabet_shift_word_reverse_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asw_pkg::*;

  localparam int DrainCycles = 200;
  localparam int NumRows = 21;
  localparam int RandomPhases = 4;
  localparam int PhaseBytes = 20;
  localparam int LongWordLetters = 68;

  typedef enum logic [2:0] {
    KeepSetup,
    SetupRing16,
    SetupDuplicates,
    SetupTiny
  } setup_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    setup_e     setup;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] typed_ch;
  } text_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;

  asw_in_if  text ();
  asw_out_if decoded ();

  alphabet_shift_word_reverse_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .text      (text),
    .decoded   (decoded)
  );

  logic [63:0] alpha_lo;
  logic [63:0] alpha_hi;
  logic [4:0]  alpha_len;
  logic [8:0]  rot;
  logic [6:0]  chunk_len;
  logic [7:0]  held [WordMax];
  int          held_n;
  int          chunk_pos;

  decoded_t    decoded_due [$];
  decoded_t    burst [$];
  text_row_t   script [NumRows];

  bit          steady;
  int          mismatches;
  int          bytes_sent;
  int          bytes_checked;
  int          setups;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("alphabet_shift_word_reverse_decoder_top verification failed");
    $finish;
  end

  function automatic void release_word();
    while (held_n > 0) begin
      held_n--;
      burst.push_back('{ch: held[held_n], last: 1'b0});
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input bit eot);
    logic [127:0] alpha_bits;
    logic [7:0]   c;
    int           n;
    int           s;
    int           r;
    int           idx;
    int           cl;
    int           lim;
    bit           letter;
    alpha_bits = {alpha_hi, alpha_lo};
    n = alpha_len;
    if (n < 1) n = 1;
    if (n > AlphabetMax) n = AlphabetMax;
    s = $signed(rot);
    r = s % n;
    if (r < 0) r += n;
    idx = -1;
    for (int i = 0; i < n; i++) begin
      if (idx < 0 && alpha_bits[8*i +: 8] == b) idx = i;
    end
    c = (idx >= 0) ? alpha_bits[8*((idx + r) % n) +: 8] : b;
    cl = chunk_len;
    if (cl < 2) cl = 2;
    if (cl > 64) cl = 64;
    lim = cl - 1;
    if (lim > WordMax) lim = WordMax;
    letter = (c >= CharLowerA && c <= CharLowerZ) || (c >= CharUpperA && c <= CharUpperZ);
    burst.delete();
    if (letter) begin
      if (held_n >= WordMax) release_word();
      held[held_n] = c;
      held_n++;
    end else begin
      release_word();
      burst.push_back('{ch: c, last: 1'b0});
    end
    chunk_pos++;
    if (c == CharNewline || chunk_pos >= lim || eot) begin
      release_word();
      chunk_pos = 0;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      RegAlphabetLow:    alpha_lo = val;
      RegAlphabetHigh:   alpha_hi = val;
      RegAlphabetLength: alpha_len = val[4:0];
      RegShift:          rot = val[8:0];
      RegChunkLength:    chunk_len = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi, input int len,
                              input int shift_amt, input int chunk);
    write_reg(RegAlphabetLow, lo);
    write_reg(RegAlphabetHigh, hi);
    write_reg(RegAlphabetLength, {59'd0, len[4:0]});
    write_reg(RegShift, {55'd0, shift_amt[8:0]});
    write_reg(RegChunkLength, {57'd0, chunk[6:0]});
    setups++;
  endtask

  task automatic settle();
    text.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] b, input bit eot, input bit use_typed,
                           input int n_typed, input logic [7:0] typed_ch);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      text.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text.valid       <= 1'b1;
    text.in_char     <= b;
    text.end_of_text <= eot;
    do @(posedge clk); while (!text.ready);
    decode_byte(b, eot);
    if (use_typed) begin
      burst.delete();
      if (n_typed > 0) burst.push_back('{ch: typed_ch, last: 1'b1});
    end
    foreach (burst[i]) decoded_due.push_back(burst[i]);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_char();
    logic [127:0] alpha_bits;
    int           k;
    alpha_bits = {alpha_hi, alpha_lo};
    k = $urandom_range(0, 99);
    if (k < 40) return alpha_bits[8*$urandom_range(0, 15) +: 8];
    if (k < 65) return ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + 8'($urandom_range(0, 25));
    if (k < 78) return 8'h20;
    if (k < 85) return CharNewline;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_setup(input bit letters_only, input int chunk);
    logic [127:0] alpha_bits;
    int           len;
    int           shift_amt;
    int           k;
    for (int i = 0; i < AlphabetMax; i++) begin
      if (letters_only || $urandom_range(0, 9) < 7)
        alpha_bits[8*i +: 8] = ($urandom_range(0, 1) ? CharLowerA : CharUpperA) +
                               8'($urandom_range(0, 25));
      else
        alpha_bits[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    k = $urandom_range(0, 9);
    len = (k < 5) ? $urandom_range(1, 16) : (k < 7) ? 16 : $urandom_range(0, 31);
    k = $urandom_range(0, 9);
    shift_amt = (k < 2) ? -255 : (k < 4) ? 255 : int'($urandom_range(0, 510)) - 255;
    apply_config(alpha_bits[63:0], alpha_bits[127:64], len, shift_amt, chunk);
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && decoded.valid && decoded.ready) begin
      bytes_checked++;
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected decoded byte %h last %b at %0t",
                   decoded.out_char, decoded.last_of_run, $realtime);
      end else begin
        want = decoded_due.pop_front();
        if (want.ch !== decoded.out_char || want.last !== decoded.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected byte %h last %b, got byte %h last %b",
                     $realtime, want.ch, want.last, decoded.out_char, decoded.last_of_run);
        end
      end
    end
  end

  initial begin
    int stall;
    decoded.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        decoded.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      decoded.ready <= 1'b1;
      do @(posedge clk); while (!decoded.valid);
    end
  end

  initial begin
    int chunk;
    int k;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    text.valid       <= 1'b0;
    text.in_char     <= 8'h00;
    text.end_of_text <= 1'b0;
    alpha_lo   = '0;
    alpha_hi   = '0;
    alpha_len  = 5'd1;
    rot        = '0;
    chunk_len  = 7'd40;
    held_n     = 0;
    chunk_pos  = 0;
    steady     = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    bytes_checked = 0;
    setups     = 0;

    script = '{
      '{8'h00, 1'b0, KeepSetup,       1'b1, 2'd1, 8'h00},
      '{8'hff, 1'b0, KeepSetup,       1'b1, 2'd1, 8'hff},
      '{"A",   1'b0, KeepSetup,       1'b1, 2'd0, 8'h00},
      '{"z",   1'b0, KeepSetup,       1'b1, 2'd0, 8'h00},
      '{" ",   1'b0, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{8'h0a, 1'b0, KeepSetup,       1'b1, 2'd1, 8'h0a},
      '{"Q",   1'b0, KeepSetup,       1'b1, 2'd0, 8'h00},
      '{"a",   1'b1, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{"a",   1'b0, SetupRing16,     1'b1, 2'd1, "b"},
      '{"p",   1'b0, KeepSetup,       1'b1, 2'd1, "a"},
      '{"q",   1'b0, KeepSetup,       1'b1, 2'd1, "q"},
      '{"!",   1'b0, KeepSetup,       1'b1, 2'd1, "!"},
      '{"g",   1'b1, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{"x",   1'b0, SetupDuplicates, 1'b1, 2'd1, 8'h00},
      '{8'h00, 1'b0, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{"H",   1'b0, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{"i",   1'b0, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{8'h80, 1'b0, KeepSetup,       1'b0, 2'd0, 8'h00},
      '{"a",   1'b0, SetupTiny,       1'b1, 2'd1, "a"},
      '{8'h0a, 1'b1, KeepSetup,       1'b1, 2'd1, 8'h0a},
      '{8'hfe, 1'b0, KeepSetup,       1'b0, 2'd0, 8'h00}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].setup != KeepSetup) begin
        settle();
        case (script[i].setup)
          SetupRing16:     apply_config("hgfedcba", "ponmlkji", 16, -255, 2);
          SetupDuplicates: apply_config("xxxxxxxx", 64'd0, 31, 255, 127);
          SetupTiny:       apply_config(64'h6261, 64'd0, 0, -1, 0);
          default: ;
        endcase
      end
      send_text(script[i].ch, script[i].eot, script[i].typed, script[i].n_typed,
                script[i].typed_ch);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      k = $urandom_range(0, 9);
      chunk = (k < 3) ? $urandom_range(2, 8) : (k < 5) ? 64 : (k < 6) ? 2 :
              (k < 8) ? $urandom_range(0, 127) : $urandom_range(2, 64);
      random_setup(1'b0, chunk);
      steady = (p == 1);
      for (int n = 0; n < PhaseBytes; n++)
        send_text(pick_char(), $urandom_range(0, 24) == 0, 1'b0, 0, 8'h00);
    end

    // A long word fills the whole chunk so the flush moves the largest burst.
    settle();
    random_setup(1'b1, 127);
    steady = 1'b0;
    send_text(CharNewline, 1'b0, 1'b0, 0, 8'h00);
    for (int n = 0; n < LongWordLetters; n++)
      send_text(($urandom_range(0, 1) ? CharLowerA : CharUpperA) + 8'($urandom_range(0, 25)),
                1'b0, 1'b0, 0, 8'h00);
    send_text(8'h20, 1'b1, 1'b0, 0, 8'h00);

    settle();
    $display("Run covered %0d text bytes under %0d register setups.", bytes_sent, setups);
    $display("Checked %0d decoded bytes, %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0 && decoded_due.size() == 0) begin
      $display("alphabet_shift_word_reverse_decoder_top verification clean");
    end else begin
      $display("alphabet_shift_word_reverse_decoder_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/asw_pkg.sv
hdl/asw_in_if.sv
hdl/asw_out_if.sv
hdl/asw_ram.sv
hdl/asw_mod.sv
hdl/alphabet_shift_word_reverse_decoder_top.sv
tb/alphabet_shift_word_reverse_decoder_top_tb.sv
